### sv/fls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_pkg
// Shared widths, reset values, register indexes and the per-LED status type
// of the fading LED scanner.
// ----------------------------------------------------------------------------
package fls_pkg;

  localparam int unsigned LEDS_MAX  = 8;
  localparam int unsigned LVL_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [LVL_W-1:0] STEP_RESET = 16'd25;
  localparam logic [LVL_W-1:0] TOP_RESET  = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LEVEL = 1'b1;

  // Direction encoding of a token
  localparam logic DIR_UP   = 1'b1;
  localparam logic DIR_DOWN = 1'b0;

  // What one LED does with the token on a tick
  typedef struct packed {
    logic take;     // picks up its pending token
    logic hand_up;  // passes the token to the next higher LED
    logic hand_dn;  // passes the token to the next lower LED
  } fls_lane_stat_t;

endpackage

### sv/fls_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fls_lane
// One LED of the scanner: brightness, phase and token direction, updated
// once per tick. Reports token pickup and hand-off to the neighbors.
// ----------------------------------------------------------------------------
module fls_lane
  import fls_pkg::*;
#(
  parameter bit IS_LOW  = 1'b0,
  parameter bit IS_HIGH = 1'b0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic [LVL_W-1:0] step_i,
  input  logic [LVL_W-1:0] top_i,
  input  logic             pend_i,
  input  logic             pend_dir_i,
  output fls_lane_stat_t   stat_o,
  output logic [LVL_W-1:0] level_next_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [LVL_W-1:0] bright_q, bright_d;
  logic             dir_q, dir_d;

  logic [LVL_W-1:0] st;
  logic [LVL_W:0]   sum;
  logic             reach;
  logic             take;

  // A zero step counts as one so a rise never stalls
  assign st  = (step_i == '0) ? {{(LVL_W-1){1'b0}}, 1'b1} : step_i;
  assign sum = {1'b0, bright_q} + {1'b0, st};

  always_comb begin
    phase_d  = phase_q;
    bright_d = bright_q;
    dir_d    = dir_q;
    reach    = 1'b0;
    take     = 1'b0;
    case (phase_q)
      PH_RISE: begin
        if (sum >= {1'b0, top_i}) begin
          bright_d = top_i;
          reach    = 1'b1;
          phase_d  = PH_FALL;
        end else begin
          bright_d = sum[LVL_W-1:0];
        end
      end
      PH_FALL: begin
        if (bright_q > st) begin
          bright_d = bright_q - st;
        end else begin
          bright_d = '0;
          phase_d  = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (pend_i) begin
          take  = 1'b1;
          dir_d = pend_dir_i;
          if (st >= top_i) begin
            bright_d = top_i;
            reach    = 1'b1;
            phase_d  = PH_FALL;
          end else begin
            bright_d = st;
            phase_d  = PH_RISE;
          end
        end
      end
    endcase
  end

  // Bounce back at the end LEDs
  always_comb begin
    stat_o.take = tick_i & take;
    if (dir_d == DIR_UP) begin
      stat_o.hand_up = tick_i & reach & ~IS_HIGH;
      stat_o.hand_dn = tick_i & reach & IS_HIGH;
    end else begin
      stat_o.hand_up = tick_i & reach & IS_LOW;
      stat_o.hand_dn = tick_i & reach & ~IS_LOW;
    end
  end

  assign level_next_o = tick_i ? bright_d : bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bright_q <= '0;
      dir_q    <= DIR_UP;
    end else if (tick_i) begin
      phase_q  <= phase_d;
      bright_q <= bright_d;
      dir_q    <= dir_d;
    end
  end

endmodule

### sv/fading_led_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fading_led_scanner_unit
// Row of LEDs that passes one token back and forth with a fade-in/fade-out.
//
// Input channel (in_valid_i / in_ready_o, advance_i): each transfer is one
// time step; advance_i = 1 lets one tick elapse, 0 holds all state. Every
// transfer yields exactly one result on the output channel (out_valid_o /
// out_ready_i, led0_level_o .. led7_level_o): the brightness of every LED
// after that step. LEDs at or above NUM_LEDS read as zero.
// The result is in the output register on the cycle after the input
// transfer. Throughput is one item per cycle while the receiver keeps up;
// every LED has its own small next-state logic, all updated in parallel.
// If the receiver stalls, the result holds in the output register and
// in_ready_o stays high only while that register is being emptied in the
// same cycle, so nothing is lost.
// Reset puts all LEDs dark and idle with an upward token pending at LED 0,
// step size 25, top level 1000. The user must write registers (cfg_we_i,
// cfg_index_i 0 step/1 top, cfg_wdata_i) only while idle; not enforced.
// ----------------------------------------------------------------------------
module fading_led_scanner_unit
  import fls_pkg::*;
#(
  parameter int unsigned NUM_LEDS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LVL_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 advance_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LVL_W-1:0]     led0_level_o,
  output logic [LVL_W-1:0]     led1_level_o,
  output logic [LVL_W-1:0]     led2_level_o,
  output logic [LVL_W-1:0]     led3_level_o,
  output logic [LVL_W-1:0]     led4_level_o,
  output logic [LVL_W-1:0]     led5_level_o,
  output logic [LVL_W-1:0]     led6_level_o,
  output logic [LVL_W-1:0]     led7_level_o
);

  logic [LVL_W-1:0] step_q, top_q;

  logic accept;
  logic tick;
  logic out_valid_q;

  logic [NUM_LEDS-1:0] pend_q, pend_d;
  logic [NUM_LEDS-1:0] pdir_q, pdir_d;
  fls_lane_stat_t [NUM_LEDS-1:0] stat;

  logic [LEDS_MAX-1:0][LVL_W-1:0] level_next;
  logic [LEDS_MAX-1:0][LVL_W-1:0] level_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign tick       = accept & advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      top_q  <= TOP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_SIZE: step_q <= cfg_wdata_i;
        CFG_TOP_LEVEL: top_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < LEDS_MAX; i++) begin : g_led
    if (i < NUM_LEDS) begin : g_used
      logic from_lo, from_hi;

      fls_lane #(
        .IS_LOW  (i == 0),
        .IS_HIGH (i == NUM_LEDS - 1)
      ) u_lane (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .tick_i       (tick),
        .step_i       (step_q),
        .top_i        (top_q),
        .pend_i       (pend_q[i]),
        .pend_dir_i   (pdir_q[i]),
        .stat_o       (stat[i]),
        .level_next_o (level_next[i])
      );

      if (i > 0) begin : g_lo
        assign from_lo = stat[i-1].hand_up;
      end else begin : g_no_lo
        assign from_lo = 1'b0;
      end
      if (i < NUM_LEDS - 1) begin : g_hi
        assign from_hi = stat[i+1].hand_dn;
      end else begin : g_no_hi
        assign from_hi = 1'b0;
      end

      // A hand-off from the higher LED wins over pickup and the lower LED
      assign pend_d[i] = from_hi | ((pend_q[i] | from_lo) & ~stat[i].take);
      assign pdir_d[i] = from_hi ? DIR_DOWN : (from_lo ? DIR_UP : pdir_q[i]);
    end else begin : g_unused
      assign level_next[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= {{(NUM_LEDS-1){1'b0}}, 1'b1};
      pdir_q <= {NUM_LEDS{DIR_UP}};
    end else if (tick) begin
      pend_q <= pend_d;
      pdir_q <= pdir_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on every input transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= level_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign led0_level_o = level_q[0];
  assign led1_level_o = level_q[1];
  assign led2_level_o = level_q[2];
  assign led3_level_o = level_q[3];
  assign led4_level_o = level_q[4];
  assign led5_level_o = level_q[5];
  assign led6_level_o = level_q[6];
  assign led7_level_o = level_q[7];

endmodule
